/* hw/rtl/jcp_pkg.sv */
package jcp_pkg;

  // default chain limits
  localparam int MAX_DEVICES_DEF = 32;
  localparam int MAX_IR_BITS_DEF = 32;

  // item kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // idcode sanity limits
  localparam logic [6:0] ID_CODE_MIN = 7'd2;
  localparam logic [6:0] ID_CODE_MAX = 7'd126;
  localparam logic [3:0] ID_BANK_MAX = 4'd8;
  localparam logic [4:0] COUNT_SAT   = 5'd31;

  // input item
  typedef struct packed {
    logic        req_type;
    logic        tdo;
    logic [31:0] pattern;
  } req_t;

  // result item
  typedef struct packed {
    logic        tms;
    logic        tdi;
    logic        done_res;
    logic [4:0]  device_count;
    logic        bypass_ok;
    logic [31:0] id_word;
    logic        id_strobe;
    logic        id_valid;
    logic        found;
  } res_t;

  // mirror a 32-bit word end for end
  function automatic logic [31:0] bit_rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // manufacturer code and bank plausibility
  function automatic logic id_is_valid(input logic [31:0] id);
    logic [6:0] code;
    logic [3:0] bank;
    code = {1'b0, id[6:1]};
    bank = id[11:8];
    return (code >= ID_CODE_MIN) && (code <= ID_CODE_MAX) && (bank <= ID_BANK_MAX);
  endfunction

endpackage

/* hw/rtl/jtag_chain_probe.sv */
// path: an item is registered in the input register, then passes through the
// sequencer, and its result is registered in the result register
// throughput: one item per cycle while the result side does not stall; the sequencer state is updated in a single pass
// reset: synchronous, active high; sequencer goes idle and both stages empty
module jtag_chain_probe import jcp_pkg::*; #(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF,
  parameter int MAX_IR_BITS = MAX_IR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic q_valid, q_stall;
  req_t q_item;
  logic r_valid, r_stall;
  res_t r_item;

  // input register
  jcp_stage #(.T(req_t)) u_in (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_stall (req_stall),
    .up_data  (req),
    .dn_valid (q_valid),
    .dn_stall (q_stall),
    .dn_data  (q_item)
  );

  // sequencer
  jcp_seq #(
    .MAX_DEVICES (MAX_DEVICES),
    .MAX_IR_BITS (MAX_IR_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_stall  (q_stall),
    .item      (q_item),
    .res_valid (r_valid),
    .res_stall (r_stall),
    .res       (r_item)
  );

  // result register
  jcp_stage #(.T(res_t)) u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (r_valid),
    .up_stall (r_stall),
    .up_data  (r_item),
    .dn_valid (res_valid),
    .dn_stall (res_stall),
    .dn_data  (res)
  );

endmodule

/* hw/rtl/jcp_stage.sv */
module jcp_stage #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_stall,
  input  T     up_data,
  output logic dn_valid,
  input  logic dn_stall,
  output T     dn_data
);

  logic full;
  T     data;

  // hold while the downstream side is stalled
  assign up_stall = full && dn_stall;
  assign dn_valid = full;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!up_stall) begin
      full <= up_valid;
    end
  end

  // payload load, no reset
  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= up_data;
    end
  end

endmodule

/* hw/rtl/jcp_seq.sv */
module jcp_seq import jcp_pkg::*; #(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF,
  parameter int MAX_IR_BITS = MAX_IR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t item,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int CNT_W   = $clog2(MAX_DEVICES * (MAX_IR_BITS + 32) + 33);
  localparam int CC_W    = $clog2(MAX_DEVICES);
  localparam int IRF_LEN = MAX_DEVICES * MAX_IR_BITS;

  typedef enum logic [4:0] {
    PH_IDLE, PH_D_TLR, PH_D_RTI, PH_D_SIR, PH_D_IRF, PH_D_TODR, PH_D_ONES,
    PH_D_CNT, PH_D_EXIT, PH_B_TLR, PH_B_RTI, PH_B_SIR, PH_B_IRF, PH_B_TORTI,
    PH_B_SDR, PH_B_SHIFT, PH_B_EXIT, PH_I_TLR, PH_I_RTI, PH_I_SDR, PH_I_SHIFT,
    PH_I_TLR2, PH_I_RTI2
  } phase_t;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  bit_counter, bit_counter_next;
  logic [CC_W-1:0]   chain_count, chain_count_next;
  logic [31:0]       pattern_shift, pattern_shift_next;
  logic [31:0]       capture_shift, capture_shift_next;
  logic [31:0]       id_shift, id_shift_next;
  logic              id_seen, id_seen_next;
  logic              first_id_ok, first_id_ok_next;

  logic              fire;
  logic [CNT_W-1:0]  cur_len;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cc_wide;
  logic [CNT_W-1:0]  shift_len_next;
  logic              ended;
  logic              strobe;
  logic [31:0]       idw;
  logic              idv;
  logic              byp;
  logic [6:0]        cc_sat;
  logic              tms, tdi;

  // one item passes per cycle unless the result side stalls
  assign fire      = in_valid && !res_stall;
  assign in_stall  = res_stall;
  assign res_valid = in_valid;

  // edge count of the current phase
  assign cc_wide = CNT_W'(chain_count);
  always_comb begin
    case (phase)
      PH_D_TLR, PH_B_TLR, PH_I_TLR, PH_I_TLR2: cur_len = CNT_W'(5);
      PH_D_SIR, PH_B_SIR:                      cur_len = CNT_W'(4);
      PH_D_IRF:                                cur_len = CNT_W'(IRF_LEN);
      PH_D_TODR:                               cur_len = CNT_W'(5);
      PH_D_ONES:                               cur_len = CNT_W'(MAX_DEVICES);
      PH_D_CNT:                                cur_len = CNT_W'(MAX_DEVICES - 1);
      PH_D_EXIT, PH_B_TORTI, PH_B_SDR, PH_I_SDR: cur_len = CNT_W'(3);
      PH_B_IRF:   cur_len = CNT_W'(cc_wide * CNT_W'(MAX_IR_BITS));
      PH_B_SHIFT: cur_len = cc_wide + CNT_W'(32);
      PH_B_EXIT:  cur_len = CNT_W'(2);
      PH_I_SHIFT: cur_len = cc_wide << 5;
      default:    cur_len = CNT_W'(1);
    endcase
  end

  // sequencer step for one item
  always_comb begin
    phase_next         = phase;
    bit_counter_next   = bit_counter;
    chain_count_next   = chain_count;
    pattern_shift_next = pattern_shift;
    capture_shift_next = capture_shift;
    id_shift_next      = id_shift;
    id_seen_next       = id_seen;
    first_id_ok_next   = first_id_ok;
    ended              = 1'b0;
    strobe             = 1'b0;
    idw                = '0;
    idv                = 1'b0;
    cnt_inc            = bit_counter + CNT_W'(1);
    if (item.req_type == REQ_START) begin
      pattern_shift_next = item.pattern;
      chain_count_next   = '0;
      capture_shift_next = '0;
      id_shift_next      = '0;
      id_seen_next       = 1'b0;
      first_id_ok_next   = 1'b0;
      phase_next         = PH_D_TLR;
      bit_counter_next   = '0;
    end else if (phase != PH_IDLE) begin
      if (phase == PH_D_CNT && item.tdo == 1'b0) begin
        // first zero ends the bypass count
        chain_count_next = bit_counter[CC_W-1:0];
        phase_next       = PH_D_EXIT;
        bit_counter_next = '0;
      end else begin
        if (phase == PH_B_SHIFT) begin
          capture_shift_next = {capture_shift[30:0], item.tdo};
        end else if (phase == PH_I_SHIFT) begin
          id_shift_next = {id_shift[30:0], item.tdo};
          if (bit_counter[4:0] == 5'h1f) begin
            strobe       = 1'b1;
            idw          = bit_rev32(id_shift_next);
            idv          = id_is_valid(idw);
            id_seen_next = 1'b1;
            if (!id_seen) begin
              first_id_ok_next = idv;
            end
          end
        end
        if (cnt_inc >= cur_len) begin
          bit_counter_next = '0;
          case (phase)
            PH_D_CNT: begin
              // no zero in the window
              chain_count_next = '0;
              phase_next       = PH_D_EXIT;
            end
            PH_D_EXIT: begin
              if (chain_count == '0) ended = 1'b1;
              else phase_next = PH_B_TLR;
            end
            PH_B_EXIT: begin
              if (bit_rev32(capture_shift) == pattern_shift) phase_next = PH_I_TLR;
              else ended = 1'b1;
            end
            PH_I_RTI2: begin
              ended = 1'b1;
            end
            default: begin
              phase_next = phase_t'(5'(phase) + 5'd1);
            end
          endcase
        end else begin
          bit_counter_next = cnt_inc;
        end
      end
    end
    if (ended) begin
      phase_next = PH_IDLE;
    end
  end

  // pin levels for the next edge
  assign shift_len_next = CNT_W'(chain_count_next) + CNT_W'(32);
  always_comb begin
    tms = 1'b0;
    tdi = 1'b0;
    case (phase_next)
      PH_D_TLR, PH_B_TLR, PH_I_TLR: tms = 1'b1;
      PH_D_SIR, PH_B_SIR: tms = (bit_counter_next < CNT_W'(2));
      PH_D_IRF, PH_B_IRF, PH_D_ONES, PH_I_SHIFT, PH_I_RTI2: tdi = 1'b1;
      PH_D_TODR: begin
        tms = (bit_counter_next < CNT_W'(3));
        tdi = 1'b1;
      end
      PH_D_EXIT: tms = (bit_counter_next < CNT_W'(2));
      PH_B_TORTI: begin
        tms = (bit_counter_next < CNT_W'(2));
        tdi = 1'b1;
      end
      PH_B_SDR: begin
        tms = (bit_counter_next < CNT_W'(1));
        tdi = 1'b1;
      end
      PH_B_SHIFT: begin
        tms = ((bit_counter_next + CNT_W'(1)) == shift_len_next);
        tdi = (bit_counter_next < CNT_W'(32)) ? pattern_shift_next[bit_counter_next[4:0]]
                                              : 1'b0;
      end
      PH_B_EXIT: tms = (bit_counter_next < CNT_W'(1));
      PH_I_SDR:  tms = (bit_counter_next < CNT_W'(1));
      PH_I_TLR2: begin
        tms = 1'b1;
        tdi = 1'b1;
      end
      default: begin
        tms = 1'b0;
        tdi = 1'b0;
      end
    endcase
  end

  // result fields
  assign cc_sat = 7'(chain_count_next);
  assign byp    = ended && (chain_count_next != '0) &&
                  (bit_rev32(capture_shift_next) == pattern_shift_next);
  always_comb begin
    res.tms          = tms;
    res.tdi          = tdi;
    res.done_res     = ended;
    res.device_count = '0;
    if (ended) begin
      res.device_count = (cc_sat > 7'(COUNT_SAT)) ? COUNT_SAT : cc_sat[4:0];
    end
    res.bypass_ok    = byp;
    res.id_word      = idw;
    res.id_strobe    = strobe;
    res.id_valid     = idv;
    res.found        = ended && (chain_count_next != '0) && byp && first_id_ok_next;
  end

  // sequencer state and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_counter   <= '0;
      chain_count   <= '0;
      pattern_shift <= '0;
      capture_shift <= '0;
      id_shift      <= '0;
      id_seen       <= 1'b0;
      first_id_ok   <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      bit_counter   <= bit_counter_next;
      chain_count   <= chain_count_next;
      pattern_shift <= pattern_shift_next;
      capture_shift <= capture_shift_next;
      id_shift      <= id_shift_next;
      id_seen       <= id_seen_next;
      first_id_ok   <= first_id_ok_next;
    end
  end

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type == REQ_START |=> phase == PH_D_TLR && bit_counter == '0)
    else $error("start item did not restart the sequence");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> phase == PH_IDLE)
    else $error("run ended but sequencer not idle");

  a_strobe_in_shift: assert property (@(posedge clk) disable iff (rst)
    fire && res.id_strobe |-> phase == PH_I_SHIFT)
    else $error("idcode strobe outside the idcode shift");

  a_counter_in_range: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> bit_counter < cur_len)
    else $error("edge counter beyond phase length");

  a_done_pins_rest: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |-> !res.tms && !res.tdi && !res.id_strobe)
    else $error("pins not at rest when the run ends");

endmodule

/* tb/sv/testbench.sv */
module testbench import jcp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MD = MAX_DEVICES_DEF;
  localparam int MIR = MAX_IR_BITS_DEF;
  // tlr, rti, select-ir, ir fill, to shift-dr, ones flush
  localparam int PRE_COUNT_TICKS = 5 + 1 + 4 + MD * MIR + 5 + MD;

  // sequencer phases, in the order the sequencer steps through them
  typedef enum logic [4:0] {
    SQ_IDLE, SQ_D_TLR, SQ_D_RTI, SQ_D_SIR, SQ_D_IRF, SQ_D_TODR, SQ_D_ONES, SQ_D_CNT,
    SQ_D_EXIT, SQ_B_TLR, SQ_B_RTI, SQ_B_SIR, SQ_B_IRF, SQ_B_TORTI, SQ_B_SDR, SQ_B_SHIFT,
    SQ_B_EXIT, SQ_I_TLR, SQ_I_RTI, SQ_I_SDR, SQ_I_SHIFT, SQ_I_TLR2, SQ_I_RTI2
  } seq_phase_t;

  // kinds of probe run the stimulus builds
  typedef enum int {
    PLAN_ABORT, PLAN_NO_ZERO, PLAN_EMPTY, PLAN_MISMATCH, PLAN_GOOD
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  req_t pending_q[$];
  res_t probe_expect_q[$];
  int   sent_items = 0;
  int   mismatches = 0;
  int   send_wait = 0;
  int   stall_left = 0;
  int   calm_send = 0;
  int   calm_recv = 0;

  // mirrored sequencer state
  seq_phase_t  sq_phase = SQ_IDLE;
  logic [10:0] sq_edge = '0;
  logic [5:0]  sq_devices = '0;
  logic [31:0] sq_pattern = '0;
  logic [31:0] sq_capture = '0;
  logic [31:0] sq_idbits = '0;
  logic [5:0]  sq_idnum = '0;
  logic        sq_first_ok = 1'b0;

  jtag_chain_probe u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] mirror32(input logic [31:0] w);
    logic [31:0] m;
    for (int i = 0; i < 32; i++) begin
      m[i] = w[31 - i];
    end
    return m;
  endfunction

  // manufacturer code 2..63 and bank at most 8
  function automatic logic idcode_plausible(input logic [31:0] w);
    return (w[6:1] > 6'd1) && (w[11:8] <= 4'd8);
  endfunction

  function automatic int unsigned span_of(input seq_phase_t p);
    case (p)
      SQ_D_TLR, SQ_B_TLR, SQ_I_TLR, SQ_I_TLR2: return 5;
      SQ_D_SIR, SQ_B_SIR: return 4;
      SQ_D_IRF: return MD * MIR;
      SQ_D_TODR: return 5;
      SQ_D_ONES: return MD;
      SQ_D_CNT: return MD - 1;
      SQ_D_EXIT, SQ_B_TORTI, SQ_B_SDR, SQ_I_SDR: return 3;
      SQ_B_IRF: return sq_devices * MIR;
      SQ_B_SHIFT: return 32 + sq_devices;
      SQ_B_EXIT: return 2;
      SQ_I_SHIFT: return sq_devices * 32;
      default: return 1;
    endcase
  endfunction

  // advance the mirrored sequencer by one item and return the pin levels and status
  function automatic res_t probe_step(input req_t r);
    res_t        o;
    logic        ended;
    logic [31:0] word;
    o = '0;
    ended = 1'b0;
    if (r.req_type == REQ_START) begin
      sq_pattern = r.pattern;
      sq_devices = '0;
      sq_capture = '0;
      sq_idbits = '0;
      sq_idnum = '0;
      sq_first_ok = 1'b0;
      sq_phase = SQ_D_TLR;
      sq_edge = '0;
    end else if (sq_phase != SQ_IDLE) begin
      if (sq_phase == SQ_D_CNT && !r.tdo) begin
        // first zero closes the count window
        sq_devices = sq_edge[5:0];
        sq_phase = SQ_D_EXIT;
        sq_edge = '0;
      end else begin
        if (sq_phase == SQ_B_SHIFT) begin
          sq_capture = {sq_capture[30:0], r.tdo};
        end else if (sq_phase == SQ_I_SHIFT) begin
          sq_idbits = {sq_idbits[30:0], r.tdo};
          if (sq_edge[4:0] == 5'd31) begin
            word = mirror32(sq_idbits);
            o.id_strobe = 1'b1;
            o.id_word = word;
            o.id_valid = idcode_plausible(word);
            if (sq_idnum == 6'd0) sq_first_ok = o.id_valid;
            sq_idnum = sq_idnum + 6'd1;
          end
        end
        sq_edge = sq_edge + 11'd1;
        if (sq_edge >= span_of(sq_phase)) begin
          sq_edge = '0;
          case (sq_phase)
            SQ_D_CNT: begin
              // no zero inside the window
              sq_devices = '0;
              sq_phase = SQ_D_EXIT;
            end
            SQ_D_EXIT: begin
              if (sq_devices == 6'd0) ended = 1'b1;
              else sq_phase = SQ_B_TLR;
            end
            SQ_B_EXIT: begin
              if (mirror32(sq_capture) == sq_pattern) sq_phase = SQ_I_TLR;
              else ended = 1'b1;
            end
            SQ_I_RTI2: ended = 1'b1;
            default: sq_phase = seq_phase_t'(sq_phase + 5'd1);
          endcase
        end
      end
      if (ended) begin
        sq_phase = SQ_IDLE;
        o.done_res = 1'b1;
        o.device_count = (sq_devices > 6'd31) ? COUNT_SAT : sq_devices[4:0];
        if (sq_devices != 6'd0) o.bypass_ok = (mirror32(sq_capture) == sq_pattern);
        o.found = (sq_devices != 6'd0) && o.bypass_ok && sq_first_ok;
      end
    end

    // pin levels for the next edge
    case (sq_phase)
      SQ_D_TLR, SQ_B_TLR, SQ_I_TLR: o.tms = 1'b1;
      SQ_D_SIR, SQ_B_SIR: o.tms = (sq_edge < 11'd2);
      SQ_D_IRF, SQ_B_IRF, SQ_D_ONES, SQ_I_SHIFT, SQ_I_RTI2: o.tdi = 1'b1;
      SQ_D_TODR: begin
        o.tms = (sq_edge < 11'd3);
        o.tdi = 1'b1;
      end
      SQ_D_EXIT: o.tms = (sq_edge < 11'd2);
      SQ_B_TORTI: begin
        o.tms = (sq_edge < 11'd2);
        o.tdi = 1'b1;
      end
      SQ_B_SDR: begin
        o.tms = (sq_edge < 11'd1);
        o.tdi = 1'b1;
      end
      SQ_B_SHIFT: begin
        o.tms = (sq_edge + 11'd1 == span_of(SQ_B_SHIFT));
        o.tdi = (sq_edge < 11'd32) ? sq_pattern[sq_edge[4:0]] : 1'b0;
      end
      SQ_B_EXIT, SQ_I_SDR: o.tms = (sq_edge < 11'd1);
      SQ_I_TLR2: begin
        o.tms = 1'b1;
        o.tdi = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  // gap lengths: mostly none or short, a few long, with calm stretches
  task automatic draw_idle(inout int calm, output int gap);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 299) == 0) begin
      calm = $urandom_range(50, 300);
      gap = 0;
    end else if (roll < 60) begin
      gap = 0;
    end else if (roll < 88) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(12, 40);
    end
  endtask

  task automatic queue_tick(input logic level);
    req_t it;
    it.req_type = REQ_TICK;
    it.tdo = level;
    it.pattern = $urandom;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic queue_noise(input int n);
    repeat (n) queue_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic queue_start(input logic [31:0] pat);
    req_t it;
    it.req_type = REQ_START;
    it.tdo = 1'($urandom_range(0, 1));
    it.pattern = pat;
    pending_q.insert(pending_q.size(), it);
  endtask

  // one probe run as a chain of devs bypass bits would answer it
  task automatic queue_probe(input plan_t kind, input int devs);
    logic [31:0] pat;
    logic [31:0] id;
    int          flip;
    int          pick;
    pick = $urandom_range(0, 9);
    pat = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    queue_start(pat);
    if (kind == PLAN_ABORT) begin
      queue_noise($urandom_range(0, 1500));
      return;
    end
    queue_noise(PRE_COUNT_TICKS);
    // count window
    if (kind == PLAN_NO_ZERO) begin
      repeat (MD - 1) queue_tick(1'b1);
    end else begin
      repeat (devs) queue_tick(1'b1);
      queue_tick(1'b0);
    end
    queue_noise(3);
    if (kind == PLAN_NO_ZERO || devs == 0) return;
    // bypass load, then the loopback delayed by one bit per device
    queue_noise(16 + devs * MIR + devs);
    flip = (kind == PLAN_MISMATCH) ? $urandom_range(0, 31) : -1;
    for (int i = 0; i < 32; i++) begin
      queue_tick(pat[i] ^ (i == flip));
    end
    queue_noise(2);
    if (kind == PLAN_MISMATCH) return;
    // idcode read, lsb first per device
    queue_noise(9);
    repeat (devs) begin
      id = $urandom;
      if ($urandom_range(0, 2) != 0) begin
        id[0] = 1'b1;
        id[6:1] = 6'($urandom_range(2, 63));
        id[11:8] = 4'($urandom_range(0, 8));
      end
      for (int i = 0; i < 32; i++) begin
        queue_tick(id[i]);
      end
    end
    queue_noise(6);
  endtask

  function automatic string describe(input res_t r);
    return $sformatf("tms=%b tdi=%b done=%b cnt=%0d byp=%b id=%h stb=%b val=%b fnd=%b",
                     r.tms, r.tdi, r.done_res, r.device_count, r.bypass_ok, r.id_word,
                     r.id_strobe, r.id_valid, r.found);
  endfunction

  task automatic note_mismatch(input bit orphan, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan) begin
        $display("[%0t] item with nothing expected: %s", $time, describe(got));
      end else begin
        $display("[%0t] item mismatch", $time);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endtask

  // driver: present pending items, predict each one as it is taken
  always @(posedge clk) begin : drive_items
    if (rst) begin
      req_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_valid && !req_stall) begin
        probe_expect_q.insert(probe_expect_q.size(), probe_step(req));
        sent_items++;
      end
      if (!req_valid || !req_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          req_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          req <= pending_q.pop_front();
          req_valid <= 1'b1;
          draw_idle(calm_send, send_wait);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken result against the oldest prediction
  always @(posedge clk) begin : watch_results
    res_t want;
    int   hold;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (probe_expect_q.size() == 0) begin
          note_mismatch(1'b1, '0, res);
        end else begin
          want = probe_expect_q.pop_front();
          if (res !== want) note_mismatch(1'b0, want, res);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        draw_idle(calm_recv, hold);
        stall_left = (hold > 0) ? hold - 1 : 0;
        res_stall <= (hold > 0);
      end
    end
  end

  initial begin : run_probe_tests
    int    total;
    int    scan_items;
    int    full_runs;
    int    mark;
    int    roll;
    int    devs;
    plan_t kind;

    // directed: idle ticks, extreme patterns, restart while busy
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_start(32'h0000_0000);
    queue_noise(3);
    queue_start(32'hFFFF_FFFF);
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_start(32'h8000_0001);
    queue_noise(6);

    // probe runs in a fixed order of endings; each full run is over a
    // thousand ticks, so the item budget is spent after the first two
    scan_items = 0;
    full_runs = 0;
    while (scan_items < 1800) begin
      mark = pending_q.size();
      case (full_runs)
        0: begin kind = PLAN_GOOD; devs = 2; end
        1: begin kind = PLAN_NO_ZERO; devs = 0; end
        2: begin kind = PLAN_EMPTY; devs = 0; end
        3: begin kind = PLAN_MISMATCH; devs = 1; end
        4: begin kind = PLAN_GOOD; devs = MD - 2; end
        default: begin
          roll = $urandom_range(0, 99);
          kind = (roll < 15) ? PLAN_ABORT : (roll < 25) ? PLAN_NO_ZERO :
                 (roll < 35) ? PLAN_EMPTY : (roll < 50) ? PLAN_MISMATCH : PLAN_GOOD;
          roll = $urandom_range(0, 99);
          devs = (roll < 70) ? $urandom_range(1, 3) :
                 (roll < 90) ? $urandom_range(4, 8) : $urandom_range(9, MD - 2);
          if (kind == PLAN_EMPTY || kind == PLAN_NO_ZERO) devs = 0;
        end
      endcase
      queue_probe(kind, devs);
      if (kind != PLAN_ABORT) full_runs++;
      scan_items += pending_q.size() - mark;
      // a few ticks while the sequencer rests
      queue_noise($urandom_range(0, 3));
    end
    total = pending_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (sent_items < total) @(posedge clk);
    while (probe_expect_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("jtag_chain_probe verification clean");
    end else begin
      $display("jtag_chain_probe verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("jtag_chain_probe verification failed");
    $finish;
  end

endmodule
